@@ rtl/trial_division_prime_test_unit_defines.svh @@
// ----------------------------------------------------------------------------
// trial division prime test unit: assertion macros
// concurrent assertion shorthands used by tdp_checker.sv, the checker among the rtl files
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_DEFINES_SVH

// next-cycle implication, muted while reset is asserted
`define TDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define TDP_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tdp_pkg.sv @@
// ----------------------------------------------------------------------------
// tdp_pkg
// widths, sequencer states and status types of the trial division prime test
// ----------------------------------------------------------------------------
package tdp_pkg;

  // input number width and the magnitude width of a non-negative value
  localparam int NUM_W = 32;
  localparam int MAG_W = NUM_W - 1;

  // divisor never exceeds ceil(sqrt(2^31)), so half the number width holds it
  localparam int DIV_W = NUM_W / 2;

  // running square of the divisor, one bit wider than the magnitude
  localparam int SQ_W = MAG_W + 1;

  // bit counter of the serial remainder unit
  localparam int CNT_W = $clog2(MAG_W);

  localparam int FIRST_DIVISOR = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  // status from the remainder unit back to the sequencer
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

@@ rtl/tdp_rem_unit.sv @@
// ----------------------------------------------------------------------------
// tdp_rem_unit
// bit-serial restoring remainder: one dividend bit per cycle, reports zero rem
// ----------------------------------------------------------------------------
module tdp_rem_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tdp_pkg::MAG_W-1:0]    dividend,
  input  logic [tdp_pkg::DIV_W-1:0]    divisor,
  output tdp_pkg::rem_status_t         status
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tdp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [tdp_pkg::MAG_W-1:0]   shf_r, shf_nxt;
  logic [tdp_pkg::DIV_W-1:0]   rem_r, rem_nxt;
  logic [tdp_pkg::DIV_W-1:0]   dvs_r, dvs_nxt;
  logic [tdp_pkg::DIV_W:0]     trial;
  logic [tdp_pkg::DIV_W:0]     diff;
  logic                        last;

  // shift the next dividend bit in and try one subtract
  assign trial = {rem_r, shf_r[tdp_pkg::MAG_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign last  = (cnt_r == tdp_pkg::CNT_W'(tdp_pkg::MAG_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      shf_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // restoring step: keep the difference when it did not borrow
      if (!diff[tdp_pkg::DIV_W]) begin
        rem_nxt = diff[tdp_pkg::DIV_W-1:0];
      end else begin
        rem_nxt = trial[tdp_pkg::DIV_W-1:0];
      end
      shf_nxt = {shf_r[tdp_pkg::MAG_W-2:0], 1'b0};
      cnt_nxt = cnt_r + tdp_pkg::CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign status.done = done_r;
  assign status.zero = (rem_r == '0);

endmodule

@@ rtl/trial_division_prime_test_unit.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// tests a signed 32-bit number for primality by trial division
// ----------------------------------------------------------------------------
// One number is taken at a time; in_ready is low until its work is done. Values
// below two go straight to the done state. Otherwise divisors 2, 3, ... are
// tried while divisor squared does not exceed the number, each after a bound
// check and through a bit-serial remainder unit, with early exit on the first
// divisor that leaves no remainder. The divisor square is kept as a running
// sum, so no multiplier is used. A result waits in an output register, and the
// next number is accepted while it waits.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [tdp_pkg::NUM_W-1:0] in_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_prime
);

  tdp_pkg::state_t             state_r, state_nxt;
  logic [tdp_pkg::MAG_W-1:0]   n_r, n_nxt;
  logic [tdp_pkg::DIV_W-1:0]   d_r, d_nxt;
  logic [tdp_pkg::SQ_W-1:0]    sq_r, sq_nxt;
  logic                        res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_prime_r, out_prime_nxt;
  logic                        rem_start;
  logic                        below_two;
  logic                        out_free;
  tdp_pkg::rem_status_t        rem_status;

  tdp_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (n_r),
    .divisor  (d_r),
    .status   (rem_status)
  );

  // negative, zero or one
  assign below_two = in_number[tdp_pkg::NUM_W-1] || (in_number[tdp_pkg::NUM_W-2:1] == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == tdp_pkg::ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    rem_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      tdp_pkg::ST_IDLE: begin
        if (in_valid) begin
          n_nxt  = in_number[tdp_pkg::MAG_W-1:0];
          d_nxt  = tdp_pkg::DIV_W'(tdp_pkg::FIRST_DIVISOR);
          sq_nxt = tdp_pkg::SQ_W'(tdp_pkg::FIRST_DIVISOR * tdp_pkg::FIRST_DIVISOR);
          if (below_two) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::ST_DONE;
          end else begin
            state_nxt = tdp_pkg::ST_CHECK;
          end
        end
      end
      tdp_pkg::ST_CHECK: begin
        // bound reached with no divisor found
        if (sq_r > {1'b0, n_r}) begin
          res_nxt   = 1'b1;
          state_nxt = tdp_pkg::ST_DONE;
        end else begin
          rem_start = 1'b1;
          state_nxt = tdp_pkg::ST_DIV;
        end
      end
      tdp_pkg::ST_DIV: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::ST_DONE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + {{(tdp_pkg::SQ_W-tdp_pkg::DIV_W-1){1'b0}}, d_r, 1'b1};
            d_nxt     = d_r + tdp_pkg::DIV_W'(1);
            state_nxt = tdp_pkg::ST_CHECK;
          end
        end
      end
      tdp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = tdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdp_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

endmodule

@@ rtl/tdp_checker.sv @@
// ----------------------------------------------------------------------------
// tdp_checker
// port-level checks of the trial division prime test unit, bound to the top
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_unit_defines.svh"

module tdp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [tdp_pkg::NUM_W-1:0]   in_number,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_is_prime
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  // a stalled result stays and keeps its value
  `TDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_is_prime), "result dropped or changed while stalled")

  // a waiting number stays offered and keeps its value
  `TDP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_number), "input dropped or changed while waiting")

  // one number at a time: busy right after an input transfer
  `TDP_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_ready, "input accepted while a number is in work")

  // reset leaves the unit empty and ready
  `TDP_ASSERT_NEXT_RST(a_reset_state, !rst_n, !out_valid && in_ready, "unit not empty and ready after reset")

endmodule

bind trial_division_prime_test_unit tdp_checker u_tdp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_number    (in_number),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_is_prime (out_is_prime)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: trial division prime test unit testbench
// streams signed numbers through the unit and checks each is_prime answer
// against a trial division predictor, under sender and receiver idling and
// one long receiver hold-off that backs the unit up
// ----------------------------------------------------------------------------
module tb_top;
  localparam int NUM_W = tdp_pkg::NUM_W;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [NUM_W-1:0] in_number = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_is_prime;

  logic signed [NUM_W-1:0] pending_numbers[$];
  logic expected_prime[$];
  int item_total = 0;
  int numbers_taken = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int send_idle_pct;
  int recv_idle_pct;

  trial_division_prime_test_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_prime(out_is_prime)
  );

  // primality by trial division, divisor squared held wide so it never wraps
  function automatic logic prime_by_division(logic signed [NUM_W-1:0] value);
    logic [63:0] magnitude;
    logic [63:0] divisor;
    if (value < 2) return 1'b0;
    magnitude = {32'd0, value};
    for (divisor = 64'd2; divisor * divisor <= magnitude; divisor++) begin
      if (magnitude % divisor == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // idling schedule: sender light / receiver heavy, then reversed, then none
  assign send_idle_pct = (results_seen < item_total / 3) ? 25 :
                         (results_seen < 2 * item_total / 3) ? 78 : 0;
  assign recv_idle_pct = (results_seen < item_total / 3) ? 78 :
                         (results_seen < 2 * item_total / 3) ? 25 : 0;

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_number <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_numbers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_number <= pending_numbers.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once the idle-free phase is under way
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == 2 * item_total / 3 + 5) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each input transfer, check on each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_prime.push_back(prime_by_division(in_number));
        numbers_taken <= numbers_taken + 1;
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_prime.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result transfer: is_prime=%0b", out_is_prime);
          mismatch_count <= mismatch_count + 1;
        end else if (expected_prime[0] !== out_is_prime) begin
          if (mismatch_count < 10)
            $display("is_prime mismatch on result %0d: expected %0b, got %0b",
                     results_seen, expected_prime[0], out_is_prime);
          mismatch_count <= mismatch_count + 1;
          void'(expected_prime.pop_front());
        end else begin
          void'(expected_prime.pop_front());
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("trial_division_prime_test_unit test failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    int factor;
    int root;
    logic [NUM_W-1:0] raw;

    // directed: sign and small-value corners, tiny primes, squares,
    // the largest positive value and its neighbors, bit patterns
    pending_numbers.push_back(32'sh8000_0000);
    pending_numbers.push_back(-32'sd1);
    pending_numbers.push_back(32'sd0);
    pending_numbers.push_back(32'sd1);
    pending_numbers.push_back(32'sd2);
    pending_numbers.push_back(32'sd3);
    pending_numbers.push_back(32'sd4);
    pending_numbers.push_back(32'sd5);
    pending_numbers.push_back(32'sd9);
    pending_numbers.push_back(32'sd25);
    pending_numbers.push_back(32'sd49);
    pending_numbers.push_back(32'sd97);
    pending_numbers.push_back(32'sd65537);
    pending_numbers.push_back(32'sd1018081);
    pending_numbers.push_back(32'sd1000003);
    pending_numbers.push_back(32'sh7FFF_FFFF);
    pending_numbers.push_back(32'sh7FFF_FFFE);
    pending_numbers.push_back(32'sh7FFF_FFFD);
    pending_numbers.push_back(32'sh5555_5555);
    pending_numbers.push_back(32'shAAAA_AAAA);
    pending_numbers.push_back(32'sh2AAA_AAAA);

    // random: mostly small and medium values, large values only as
    // composites with a small factor so each stays quick
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        raw = $urandom_range(5000);
      end else if (kind < 55) begin
        raw = $urandom_range(200000, 5000);
      end else if (kind < 72) begin
        factor = $urandom_range(97, 2);
        raw = factor * $urandom_range(32'h7FFF_FFFF / factor, 2);
      end else if (kind < 88) begin
        raw = {1'b1, 31'($urandom)};
      end else begin
        root = $urandom_range(300, 2);
        raw = root * root;
      end
      pending_numbers.push_back(raw);
    end
    item_total = pending_numbers.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (numbers_taken < item_total) @(posedge clk);
    while (expected_prime.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("trial_division_prime_test_unit test passed");
    end else begin
      $display("trial_division_prime_test_unit test failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/tdp_pkg.sv
rtl/tdp_rem_unit.sv
rtl/trial_division_prime_test_unit.sv
rtl/tdp_checker.sv
sim/tb_top.sv
